// ===== design/halfsiphash_2_4_mac_defines.svh =====
// Assertion macros for the HalfSipHash tag unit.
`ifndef HALFSIPHASH_2_4_MAC_DEFINES_SVH
`define HALFSIPHASH_2_4_MAC_DEFINES_SVH

`ifndef ASSERT_OFF
`define HS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define HS_ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);
`else
`define HS_ASSERT(label, prop, msg)
`define HS_ASSERT_IMPL(label, cond, prop, msg)
`endif

`endif

// ===== design/hs24_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package hs24_pkg;

  localparam int COMPRESS_ROUNDS = 2;
  localparam int FINAL_ROUNDS    = 4;
  localparam int MAX_ROUNDS      = (COMPRESS_ROUNDS > FINAL_ROUNDS) ?
                                   COMPRESS_ROUNDS : FINAL_ROUNDS;
  localparam int HALF_W          = (MAX_ROUNDS > 1) ? $clog2(2 * MAX_ROUNDS) : 1;

  localparam logic [HALF_W-1:0] COMPRESS_START = HALF_W'(2 * COMPRESS_ROUNDS - 1);
  localparam logic [HALF_W-1:0] FINAL_START    = HALF_W'(2 * FINAL_ROUNDS - 1);

  localparam logic [31:0] INIT_V2    = 32'h6c796765;
  localparam logic [31:0] INIT_V3    = 32'h74656462;
  localparam logic [31:0] FINAL_MARK = 32'h000000ff;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b1;

  // Chaining words v0 to v3, v0 at index 0.
  typedef logic [3:0][31:0] sip_state_t;

endpackage
`default_nettype wire

// ===== design/halfsiphash_2_4_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none
// HalfSipHash-2-4 with a 32-bit tag over a byte stream, keyed by key_low and key_high.
// One byte at most is taken per transfer. A byte that does not complete a word leaves the
// block ready for the next transfer; the fourth byte of a word stalls the input while
// COMPRESS_ROUNDS rounds compress the word, every round running as two half-rounds
// through a single shared round unit. A transfer that ends the message adds the tail
// word's compression, FINAL_ROUNDS rounds of finalization and a load of the tag register
// (held off while an earlier tag waits), after which the next message may start while
// the tag waits to be taken. Writing a key register restarts the message.
`include "halfsiphash_2_4_mac_defines.svh"
module halfsiphash_2_4_mac
  import hs24_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cfg_we,
  input  wire [CFG_IDX_W-1:0] cfg_index,
  input  wire [31:0]          cfg_data,
  input  wire                 item_valid,
  output logic                item_stall,
  input  wire [7:0]           data_byte,
  input  wire                 byte_valid,
  input  wire                 last_byte,
  output logic                tag_valid,
  input  wire                 tag_stall,
  output logic [31:0]         tag
);

  typedef enum logic [1:0] {ST_IDLE, ST_RND, ST_EMIT} state_t;
  typedef enum logic [1:0] {SG_WORD, SG_TAIL, SG_FINAL} stage_t;

  state_t            state, state_next;
  stage_t            stage, stage_next;
  logic [HALF_W-1:0] cnt, cnt_next;
  logic [31:0]       key_low, key_low_next;
  logic [31:0]       key_high, key_high_next;
  sip_state_t        v, v_next;
  sip_state_t        rnd_out;
  logic [23:0]       partial_word, partial_word_next;
  logic [1:0]        lane_count, lane_count_next;
  logic [7:0]        message_length, message_length_next;
  logic [31:0]       word_m, word_m_next;
  logic              last_pend, last_pend_next;
  logic [31:0]       tag_next;
  logic              tag_valid_next;

  logic              accept;
  logic              acc_full;
  logic [23:0]       acc_pw;
  logic [1:0]        acc_ln;
  logic [7:0]        acc_len;
  logic [31:0]       acc_word;
  logic [31:0]       tail_word;

  hs24_round u_round (
    .v           (v),
    .second_half (~cnt[0]),
    .v_out       (rnd_out)
  );

  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign tail_word  = {message_length, partial_word};

  always_comb begin
    acc_full = 1'b0;
    acc_pw   = partial_word;
    acc_ln   = lane_count;
    acc_len  = message_length;
    acc_word = {data_byte, partial_word};
    if (byte_valid) begin
      acc_len = message_length + 8'd1;
      if (lane_count == 2'd3) begin
        acc_full = 1'b1;
        acc_pw   = 24'd0;
        acc_ln   = 2'd0;
      end else begin
        acc_pw = partial_word | ({16'd0, data_byte} << {lane_count, 3'b000});
        acc_ln = lane_count + 2'd1;
      end
    end
  end

  always_comb begin
    state_next          = state;
    stage_next          = stage;
    cnt_next            = cnt;
    key_low_next        = key_low;
    key_high_next       = key_high;
    v_next              = v;
    partial_word_next   = partial_word;
    lane_count_next     = lane_count;
    message_length_next = message_length;
    word_m_next         = word_m;
    last_pend_next      = last_pend;
    tag_next            = tag;
    tag_valid_next      = tag_valid;

    if (tag_valid && !tag_stall) begin
      tag_valid_next = 1'b0;
    end

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          partial_word_next   = acc_pw;
          lane_count_next     = acc_ln;
          message_length_next = acc_len;
          last_pend_next      = last_byte;
          cnt_next            = COMPRESS_START;
          if (acc_full) begin
            v_next[3]   = v[3] ^ acc_word;
            word_m_next = acc_word;
            stage_next  = SG_WORD;
            state_next  = ST_RND;
          end else if (last_byte) begin
            v_next[3]   = v[3] ^ {acc_len, acc_pw};
            word_m_next = {acc_len, acc_pw};
            stage_next  = SG_TAIL;
            state_next  = ST_RND;
          end
        end
      end
      ST_RND: begin
        v_next = rnd_out;
        if (cnt == '0) begin
          unique case (stage)
            SG_WORD: begin
              v_next[0] = rnd_out[0] ^ word_m;
              if (last_pend) begin
                v_next[3]   = rnd_out[3] ^ tail_word;
                word_m_next = tail_word;
                stage_next  = SG_TAIL;
                cnt_next    = COMPRESS_START;
              end else begin
                state_next = ST_IDLE;
              end
            end
            SG_TAIL: begin
              v_next[0]  = rnd_out[0] ^ word_m;
              v_next[2]  = rnd_out[2] ^ FINAL_MARK;
              stage_next = SG_FINAL;
              cnt_next   = FINAL_START;
            end
            SG_FINAL: begin
              state_next = ST_EMIT;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end else begin
          cnt_next = cnt - HALF_W'(1);
        end
      end
      ST_EMIT: begin
        if (!tag_valid || !tag_stall) begin
          tag_next            = v[1] ^ v[3];
          tag_valid_next      = 1'b1;
          v_next[0]           = key_low;
          v_next[1]           = key_high;
          v_next[2]           = key_low ^ INIT_V2;
          v_next[3]           = key_high ^ INIT_V3;
          partial_word_next   = 24'd0;
          lane_count_next     = 2'd0;
          message_length_next = 8'd0;
          last_pend_next      = 1'b0;
          state_next          = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_LOW:  key_low_next  = cfg_data;
        REG_KEY_HIGH: key_high_next = cfg_data;
        default:      key_low_next  = key_low;
      endcase
      v_next[0]           = key_low_next;
      v_next[1]           = key_high_next;
      v_next[2]           = key_low_next ^ INIT_V2;
      v_next[3]           = key_high_next ^ INIT_V3;
      partial_word_next   = 24'd0;
      lane_count_next     = 2'd0;
      message_length_next = 8'd0;
      last_pend_next      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      stage          <= SG_WORD;
      cnt            <= '0;
      key_low        <= 32'd0;
      key_high       <= 32'd0;
      v[0]           <= 32'd0;
      v[1]           <= 32'd0;
      v[2]           <= INIT_V2;
      v[3]           <= INIT_V3;
      partial_word   <= 24'd0;
      lane_count     <= 2'd0;
      message_length <= 8'd0;
      last_pend      <= 1'b0;
      tag_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      stage          <= stage_next;
      cnt            <= cnt_next;
      key_low        <= key_low_next;
      key_high       <= key_high_next;
      v              <= v_next;
      partial_word   <= partial_word_next;
      lane_count     <= lane_count_next;
      message_length <= message_length_next;
      last_pend      <= last_pend_next;
      tag_valid      <= tag_valid_next;
    end
    word_m <= word_m_next;
    tag    <= tag_next;
  end

  `HS_ASSERT(a_partial_clean, (partial_word >> {lane_count, 3'b000}) == 24'd0, "stale tail bytes")
  `HS_ASSERT_IMPL(a_tag_from_emit, $rose(tag_valid), $past(state) == ST_EMIT, "tag outside emit")
  `HS_ASSERT_IMPL(a_emit_leaves, state == ST_EMIT && !(tag_valid && tag_stall), ##1 (state == ST_IDLE && tag_valid), "emit did not load tag")
  `HS_ASSERT_IMPL(a_final_emits, state == ST_RND && stage == SG_FINAL && cnt == '0, ##1 state == ST_EMIT, "finalization lost")

endmodule
`default_nettype wire

// ===== design/hs24_round.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hs24_round
  import hs24_pkg::*;
(
  input  sip_state_t v,
  input  logic       second_half,
  output sip_state_t v_out
);

  logic [31:0] a_sum;
  logic [31:0] c_sum;
  logic [31:0] a_in;
  logic [31:0] b_in;
  logic [31:0] c_in;
  logic [31:0] d_in;

  assign a_in = v[0];
  assign b_in = v[1];
  assign c_in = v[2];
  assign d_in = v[3];

  // The first half adds b into a and d into c; the second adds d into a and b into c.
  assign a_sum = second_half ? (a_in + d_in) : (a_in + b_in);
  assign c_sum = second_half ? (c_in + b_in) : (c_in + d_in);

  always_comb begin
    if (second_half) begin
      v_out[0] = a_sum;
      v_out[3] = {d_in[24:0], d_in[31:25]} ^ a_sum;
      v_out[1] = {b_in[18:0], b_in[31:19]} ^ c_sum;
      v_out[2] = {c_sum[15:0], c_sum[31:16]};
    end else begin
      v_out[1] = {b_in[26:0], b_in[31:27]} ^ a_sum;
      v_out[0] = {a_sum[15:0], a_sum[31:16]};
      v_out[2] = c_sum;
      v_out[3] = {d_in[23:0], d_in[31:24]} ^ c_sum;
    end
  end

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import hs24_pkg::*;

  localparam int WORD_ROUNDS = 2;
  localparam int TAIL_ROUNDS = 4;
  localparam logic [31:0] SEED_V2 = 32'h6c796765;
  localparam logic [31:0] SEED_V3 = 32'h74656462;
  localparam logic [31:0] END_MARK = 32'h000000ff;
  localparam int SETTLE_CYCLES = 40;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_ITEMS = 240;
  localparam int NUM_PHASES = 6;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       ends;
  } byte_item_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_KEY_LOW;
  logic [31:0]          cfg_data = '0;
  logic                 item_valid = 1'b0;
  logic [7:0]           data_byte = '0;
  logic                 byte_valid = 1'b0;
  logic                 last_byte = 1'b0;
  logic                 tag_stall = 1'b0;
  logic                 item_stall;
  logic                 tag_valid;
  logic [31:0]          tag;

  halfsiphash_2_4_mac dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .data_byte (data_byte),
    .byte_valid(byte_valid),
    .last_byte (last_byte),
    .tag_valid (tag_valid),
    .tag_stall (tag_stall),
    .tag       (tag)
  );

  always #10 clk = ~clk;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int quiet_cycles = 0;
  int counted_items = 0;

  logic [31:0] key_word [2];
  sip_state_t  chain;
  logic [23:0] tail_word;
  logic [1:0]  tail_count;
  logic [7:0]  msg_len;
  logic [31:0] expected_tags [$];
  logic [31:0] want_tag;
  byte_item_t  directed_rows [23];

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic sip_state_t mix_round(input sip_state_t s);
    logic [31:0] a, b, c, d;
    a = s[0];
    b = s[1];
    c = s[2];
    d = s[3];
    a = a + b; b = rotl(b, 5); b = b ^ a; a = rotl(a, 16);
    c = c + d; d = rotl(d, 8); d = d ^ c;
    a = a + d; d = rotl(d, 7); d = d ^ a;
    c = c + b; b = rotl(b, 13); b = b ^ c; c = rotl(c, 16);
    return {d, c, b, a};
  endfunction

  function automatic void restart_message();
    chain[0] = key_word[0];
    chain[1] = key_word[1];
    chain[2] = key_word[0] ^ SEED_V2;
    chain[3] = key_word[1] ^ SEED_V3;
    tail_word = '0;
    tail_count = '0;
    msg_len = '0;
  endfunction

  function automatic void absorb_word(input logic [31:0] m);
    chain[3] = chain[3] ^ m;
    for (int r = 0; r < WORD_ROUNDS; r++) chain = mix_round(chain);
    chain[0] = chain[0] ^ m;
  endfunction

  function automatic void predict_tag(input byte_item_t it);
    if (it.has_byte) begin
      msg_len = msg_len + 8'd1;
      if (tail_count == 2'd3) begin
        absorb_word({it.data, tail_word});
        tail_word = '0;
        tail_count = '0;
      end else begin
        tail_word = tail_word | (24'(it.data) << (8 * int'(tail_count)));
        tail_count = tail_count + 2'd1;
      end
    end
    if (it.ends) begin
      absorb_word({msg_len, tail_word});
      chain[2] = chain[2] ^ END_MARK;
      for (int r = 0; r < TAIL_ROUNDS; r++) chain = mix_round(chain);
      expected_tags.push_back(chain[1] ^ chain[3]);
      restart_message();
    end
  endfunction

  task automatic send_item(input byte_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    data_byte <= it.data;
    byte_valid <= it.has_byte;
    last_byte <= it.ends;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predict_tag(it);
    if (it.has_byte || it.ends) counted_items++;
  endtask

  task automatic send_message(input int len, input bit split_end);
    byte_item_t it;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) begin
        it = '{data: 8'($urandom), has_byte: 1'b0, ends: 1'b0};
        send_item(it);
      end
      it = '{data: 8'($urandom), has_byte: 1'b1, ends: (i == len - 1) && !split_end};
      send_item(it);
    end
    if (split_end || len == 0) begin
      it = '{data: 8'($urandom), has_byte: 1'b0, ends: 1'b1};
      send_item(it);
    end
  endtask

  // The block may still be compressing a word after the last tag, so it is
  // given time to settle before any key write.
  task automatic quiesce();
    item_valid <= 1'b0;
    while (expected_tags.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_keys(input logic [31:0] k0, input logic [31:0] k1);
    cfg_we <= 1'b1;
    cfg_index <= REG_KEY_LOW;
    cfg_data <= k0;
    @(posedge clk);
    key_word[0] = k0;
    restart_message();
    cfg_index <= REG_KEY_HIGH;
    cfg_data <= k1;
    @(posedge clk);
    key_word[1] = k1;
    restart_message();
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    tag_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && tag_valid && !tag_stall) begin
      if (expected_tags.size() == 0) begin
        $display("%0t: tag transfer with none expected, actual %08h", $time, tag);
        errors++;
      end else begin
        want_tag = expected_tags.pop_front();
        if (tag !== want_tag) begin
          $display("%0t: tag expected %08h, actual %08h", $time, want_tag, tag);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (tag_valid && !tag_stall) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("FAIL halfsiphash_2_4_mac");
      $finish;
    end
  end

  initial begin
    int goal;
    logic [31:0] k0, k1;
    int abandon_len;
    byte_item_t it;

    // The directed rows run under the all-zero key left by reset.
    directed_rows = '{
      '{8'h00, 1'b0, 1'b1},
      '{8'h00, 1'b0, 1'b0},
      '{8'h00, 1'b1, 1'b1},
      '{8'hff, 1'b1, 1'b1},
      '{8'h01, 1'b1, 1'b0},
      '{8'h02, 1'b1, 1'b1},
      '{8'haa, 1'b1, 1'b0},
      '{8'h55, 1'b1, 1'b0},
      '{8'h80, 1'b1, 1'b1},
      '{8'h11, 1'b1, 1'b0},
      '{8'h22, 1'b1, 1'b0},
      '{8'h33, 1'b1, 1'b0},
      '{8'h44, 1'b1, 1'b1},
      '{8'hde, 1'b1, 1'b0},
      '{8'had, 1'b1, 1'b0},
      '{8'hbe, 1'b1, 1'b0},
      '{8'hef, 1'b1, 1'b0},
      '{8'h00, 1'b0, 1'b1},
      '{8'h7f, 1'b1, 1'b0},
      '{8'h5a, 1'b0, 1'b0},
      '{8'hfe, 1'b1, 1'b1},
      '{8'hc3, 1'b1, 1'b0},
      '{8'h3c, 1'b1, 1'b0}
    };
    key_word[0] = '0;
    key_word[1] = '0;
    restart_message();
    send_idle_pct = 37;
    recv_stall_pct = 86;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) send_item(directed_rows[i]);

    // Each phase begins with a key write, which also drops whatever message
    // the previous phase left unfinished.
    for (int p = 0; p < NUM_PHASES; p++) begin
      quiesce();
      case (p)
        0: begin k0 = 32'hffffffff; k1 = 32'hffffffff; end
        1: begin k0 = 32'h03020100; k1 = 32'h07060504; end
        3: begin k0 = 32'h00000000; k1 = 32'hffffffff; end
        5: begin k0 = 32'hffffffff; k1 = 32'h00000000; end
        default: begin k0 = $urandom; k1 = $urandom; end
      endcase
      write_keys(k0, k1);
      send_idle_pct = (p < 2) ? 37 : (p < 4) ? 86 : 0;
      recv_stall_pct = (p < 2) ? 86 : (p < 4) ? 37 : 0;
      goal = counted_items + PHASE_ITEMS;
      if (p % 2 == 1) send_message($urandom_range(256, 300), 1'($urandom_range(1)));
      while (counted_items < goal) begin
        if ($urandom_range(11) == 0) begin
          send_message($urandom_range(200, 300), 1'($urandom_range(1)));
        end else begin
          send_message($urandom_range(12), 1'($urandom_range(1)));
        end
      end
      abandon_len = $urandom_range(3);
      for (int i = 0; i < abandon_len; i++) begin
        it = '{data: 8'($urandom), has_byte: 1'b1, ends: 1'b0};
        send_item(it);
      end
    end
    quiesce();

    if (errors == 0 && expected_tags.size() == 0) begin
      $display("PASS halfsiphash_2_4_mac");
    end else begin
      $display("FAIL halfsiphash_2_4_mac");
    end
    $finish;
  end

endmodule
